[rtl/mit_pkg.sv]
// ----------------------------------------------------------------------------
// mit_pkg: shared types and constants for the 3x3 inverse transpose
// Fixed-point formats, derived widths and the transaction structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mit_pkg;

  localparam int IN_WIDTH    = 16;
  localparam int IN_FRAC     = 12;
  localparam int OUT_WIDTH   = 32;
  localparam int OUT_FRAC    = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int NUM_ELEM    = 9;

  // product, cofactor, determinant term and determinant sum widths
  localparam int PW  = 2 * IN_WIDTH;
  localparam int CW  = 2 * IN_WIDTH + 1;
  localparam int CMW = 2 * IN_WIDTH;
  localparam int DPW = IN_WIDTH + CW;
  localparam int DW  = DPW + 2;
  localparam int DMW = 3 * IN_WIDTH;
  // divider: dividend shift (fraction plus guard bit), quotient bits, remainder
  localparam int SH  = IN_FRAC + OUT_FRAC + 1;
  localparam int QB  = OUT_WIDTH + 1;
  localparam int RW  = DMW + 1;
  localparam int XW  = CMW + SH + QB + DMW;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] m11;
    logic signed [IN_WIDTH-1:0] m12;
    logic signed [IN_WIDTH-1:0] m13;
    logic signed [IN_WIDTH-1:0] m21;
    logic signed [IN_WIDTH-1:0] m22;
    logic signed [IN_WIDTH-1:0] m23;
    logic signed [IN_WIDTH-1:0] m31;
    logic signed [IN_WIDTH-1:0] m32;
    logic signed [IN_WIDTH-1:0] m33;
  } mit_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] r11;
    logic signed [OUT_WIDTH-1:0] r12;
    logic signed [OUT_WIDTH-1:0] r13;
    logic signed [OUT_WIDTH-1:0] r21;
    logic signed [OUT_WIDTH-1:0] r22;
    logic signed [OUT_WIDTH-1:0] r23;
    logic signed [OUT_WIDTH-1:0] r31;
    logic signed [OUT_WIDTH-1:0] r32;
    logic signed [OUT_WIDTH-1:0] r33;
    logic                        singular;
  } mit_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [NUM_ELEM-1:0][CMW-1:0] nmag;
    logic [NUM_ELEM-1:0]          neg;
    logic [DMW-1:0]               dmag;
    logic                         singular;
  } mit_entry_t;

endpackage

`default_nettype wire

[rtl/mit_front.sv]
// ----------------------------------------------------------------------------
// mit_front: cofactor and determinant pipeline
// Five stages; forms magnitudes and signs of the cofactors and |det|.
// ----------------------------------------------------------------------------
`default_nettype none

module mit_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire mit_pkg::mit_in_t   mat,
  input  wire logic               advance,
  output logic                    ent_valid,
  output mit_pkg::mit_entry_t     ent
);

  localparam int IW  = mit_pkg::IN_WIDTH;
  localparam int NE  = mit_pkg::NUM_ELEM;
  localparam int PW  = mit_pkg::PW;
  localparam int CW  = mit_pkg::CW;
  localparam int CMW = mit_pkg::CMW;
  localparam int DPW = mit_pkg::DPW;
  localparam int DW  = mit_pkg::DW;
  localparam int DMW = mit_pkg::DMW;

  // operand pairs: cofactor k = prod[2k] - prod[2k+1]
  localparam int PA [2*NE] = '{4, 5, 5, 3, 3, 4, 2, 1, 0, 2, 1, 0, 1, 2, 2, 0, 0, 1};
  localparam int PB [2*NE] = '{8, 7, 6, 8, 7, 6, 7, 8, 8, 6, 6, 7, 5, 4, 3, 5, 4, 3};

  logic                 v1, v2, v3, v4, v5;
  logic signed [IW-1:0] m      [NE];
  logic signed [PW-1:0] prod   [2*NE];
  logic signed [IW-1:0] row_s2 [3];
  logic signed [IW-1:0] row_s3 [3];
  logic signed [CW-1:0] cof    [NE];
  logic signed [DPW-1:0] dprod [3];
  logic [CMW-1:0]       cmag4  [NE];
  logic [NE-1:0]        cneg4;
  logic [CMW-1:0]       cmag5  [NE];
  logic [NE-1:0]        cneg5;
  logic signed [DW-1:0] det;
  logic [DW-1:0]        dabs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (advance) begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m[0] <= mat.m11; m[1] <= mat.m12; m[2] <= mat.m13;
      m[3] <= mat.m21; m[4] <= mat.m22; m[5] <= mat.m23;
      m[6] <= mat.m31; m[7] <= mat.m32; m[8] <= mat.m33;
      for (int i = 0; i < 2*NE; i++) begin
        prod[i] <= m[PA[i]] * m[PB[i]];
      end
      for (int i = 0; i < 3; i++) begin
        row_s2[i] <= m[i];
        row_s3[i] <= row_s2[i];
      end
      for (int i = 0; i < NE; i++) begin
        cof[i] <= CW'(prod[2*i]) - CW'(prod[2*i+1]);
      end
      for (int i = 0; i < 3; i++) begin
        dprod[i] <= DPW'(row_s3[i]) * DPW'(cof[i]);
      end
      for (int i = 0; i < NE; i++) begin
        cneg4[i] <= cof[i][CW-1];
        cmag4[i] <= cof[i][CW-1] ? CMW'(-cof[i]) : CMW'(cof[i]);
        cmag5[i] <= cmag4[i];
      end
      cneg5 <= cneg4;
      det   <= DW'(dprod[0]) + DW'(dprod[1]) + DW'(dprod[2]);
    end
  end

  always_comb begin
    dabs      = det[DW-1] ? DW'(-det) : DW'(det);
    ent_valid = v5;
    for (int i = 0; i < NE; i++) begin
      ent.nmag[i] = cmag5[i];
    end
    ent.neg      = cneg5 ^ {NE{det[DW-1]}};
    ent.dmag     = dabs[DMW-1:0];
    ent.singular = (det == '0);
  end

endmodule

`default_nettype wire

[rtl/mit_queue.sv]
// ----------------------------------------------------------------------------
// mit_queue: short queue between front and back
// Register-array FIFO with head and tail pointers and a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module mit_queue #(
  parameter int DEPTH = mit_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr,
  input  wire mit_pkg::mit_entry_t wdata,
  input  wire logic                rd,
  output mit_pkg::mit_entry_t      rdata,
  output logic                     empty,
  output logic                     full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  mit_pkg::mit_entry_t store [DEPTH];
  logic [AW-1:0] head, tail;
  logic [NW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == NW'(DEPTH));
  assign rdata = store[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        tail <= (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (rd) begin
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      store[tail] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/mit_back.sv]
// ----------------------------------------------------------------------------
// mit_back: pipelined scaled divider and result register
// Nine restoring-division lanes, one quotient bit per stage, then round/sat.
// ----------------------------------------------------------------------------
`default_nettype none

module mit_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                ent_valid,
  input  wire mit_pkg::mit_entry_t ent,
  output logic                     ent_take,
  output mit_pkg::mit_out_t        res,
  output logic                     res_valid,
  input  wire logic                res_pop
);

  localparam int NE  = mit_pkg::NUM_ELEM;
  localparam int OW  = mit_pkg::OUT_WIDTH;
  localparam int SH  = mit_pkg::SH;
  localparam int QB  = mit_pkg::QB;
  localparam int RW  = mit_pkg::RW;
  localparam int XW  = mit_pkg::XW;
  localparam int DMW = mit_pkg::DMW;

  logic                en;
  logic                bv    [QB+1];
  logic [NE-1:0]       bovf  [QB+1];
  logic [NE-1:0]       bneg  [QB+1];
  logic                bsing [QB+1];
  logic [DMW-1:0]      dv    [QB+1];
  logic [RW-1:0]       rem   [QB+1][NE];
  logic [QB-1:0]       quo   [QB+1][NE];
  logic [QB-1:0]       low   [QB+1][NE];

  logic [XW-1:0]       nw    [NE];
  logic [XW-1:0]       hi    [NE];
  logic [OW-1:0]       val   [NE];
  logic                ov;

  assign en       = !ov || res_pop;
  assign ent_take = en && ent_valid;

  always_comb begin
    for (int l = 0; l < NE; l++) begin
      nw[l] = XW'(ent.nmag[l]) << SH;
      hi[l] = nw[l] >> QB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t <= QB; t++) begin
        bv[t] <= 1'b0;
      end
      ov <= 1'b0;
    end else if (en) begin
      bv[0] <= ent_valid;
      for (int t = 1; t <= QB; t++) begin
        bv[t] <= bv[t-1];
      end
      ov <= bv[QB];
    end
  end

  // load stage: quotient overflow check and initial partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      bneg[0]  <= ent.neg;
      bsing[0] <= ent.singular;
      dv[0]    <= ent.dmag;
      for (int l = 0; l < NE; l++) begin
        bovf[0][l] <= hi[l] >= XW'(ent.dmag);
        rem[0][l]  <= hi[l][RW-1:0];
        low[0][l]  <= nw[l][QB-1:0];
        quo[0][l]  <= '0;
      end
    end
  end

  for (genvar t = 1; t <= QB; t++) begin : g_step
    logic [RW-1:0] sh [NE];
    logic [NE-1:0] ge;

    always_comb begin
      for (int l = 0; l < NE; l++) begin
        sh[l] = {rem[t-1][l][RW-2:0], low[t-1][l][QB-1]};
        ge[l] = sh[l] >= {1'b0, dv[t-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bovf[t]  <= bovf[t-1];
        bneg[t]  <= bneg[t-1];
        bsing[t] <= bsing[t-1];
        dv[t]    <= dv[t-1];
        for (int l = 0; l < NE; l++) begin
          rem[t][l] <= ge[l] ? sh[l] - {1'b0, dv[t-1]} : sh[l];
          quo[t][l] <= {quo[t-1][l][QB-2:0], ge[l]};
          low[t][l] <= {low[t-1][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  // round half away from zero, then saturate by sign
  always_comb begin
    logic [QB:0]   inc;
    logic [QB-1:0] rnd;
    for (int l = 0; l < NE; l++) begin
      inc = {1'b0, quo[QB][l]} + 1'b1;
      rnd = inc[QB:1];
      if (bsing[QB]) begin
        val[l] = '0;
      end else if (bneg[QB][l]) begin
        if (bovf[QB][l] || rnd > {2'b01, {(OW-1){1'b0}}}) begin
          val[l] = {1'b1, {(OW-1){1'b0}}};
        end else begin
          val[l] = OW'(-rnd);
        end
      end else begin
        if (bovf[QB][l] || rnd > {2'b00, {(OW-1){1'b1}}}) begin
          val[l] = {1'b0, {(OW-1){1'b1}}};
        end else begin
          val[l] = rnd[OW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.r11      <= val[0];
      res.r12      <= val[1];
      res.r13      <= val[2];
      res.r21      <= val[3];
      res.r22      <= val[4];
      res.r23      <= val[5];
      res.r31      <= val[6];
      res.r32      <= val[7];
      res.r33      <= val[8];
      res.singular <= bsing[QB];
    end
  end

  assign res_valid = ov;

endmodule

`default_nettype wire

[rtl/matrix3_inverse_transpose.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse_transpose: 3x3 matrix inverse transpose, Q4.12 in, Q16.16 out
// Each input transaction is one matrix; each gives one result transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive mat and raise push; the transaction is taken at a
//   rising edge with push high and full low. Result channel: while empty is
//   low, res holds the oldest result; raise pop to take it.
//   res carries r(i,j) = C(i,j) / det rounded half away from zero and
//   saturated to Q16.16, or all zeros with singular set when det is zero.
// Pipeline: with no stall, an accepted matrix passes through 5 front stages
//   (input register, products, cofactors, determinant terms, sum), one queue
//   slot, a load stage, 33 divider stages (one quotient bit each) and the
//   result register before empty goes low.
// Throughput: one matrix per cycle unless stalled; one item per divider stage.
// Stall: when a result waits and pop stays low the back pipeline holds;
//   the front keeps accepting until the queue fills, then full rises.
// Reset: rst clears all valid bits, pointers and counts; the block is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3_inverse_transpose #(
  parameter int QUEUE_DEPTH = mit_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire mit_pkg::mit_in_t  mat,
  output logic                   empty,
  input  wire logic              pop,
  output mit_pkg::mit_out_t      res
);

  logic                advance;
  logic                q_full;
  logic                q_empty;
  logic                fe_valid;
  logic                be_take;
  logic                res_valid;
  mit_pkg::mit_entry_t fe_ent;
  mit_pkg::mit_entry_t q_ent;

  // hold the whole front while the queue has no free slot
  assign advance = !q_full;
  assign full    = q_full;
  assign empty   = !res_valid;

  mit_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (push && !q_full),
    .mat       (mat),
    .advance   (advance),
    .ent_valid (fe_valid),
    .ent       (fe_ent)
  );

  mit_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (fe_valid && advance),
    .wdata (fe_ent),
    .rd    (be_take),
    .rdata (q_ent),
    .empty (q_empty),
    .full  (q_full)
  );

  // back advances whenever the result register is free or being drained
  mit_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ent_valid (!q_empty),
    .ent       (q_ent),
    .ent_take  (be_take),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

endmodule

`default_nettype wire

[bench/matrix3_inverse_transpose_test.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse_transpose_test: self-checking bench for the inverse transpose
// Directed and random matrices are pushed through the block under random
// push and pop gaps. Each result is compared with a local exact-integer
// prediction of the cofactors over the determinant, rounded and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3_inverse_transpose_test;

  localparam int NUM_RANDOM = 1530;
  localparam int LATENCY    = 40;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  mit_pkg::mit_in_t   mat;
  logic               empty;
  logic               pop;
  mit_pkg::mit_out_t  res;

  mit_pkg::mit_in_t   pending_mats[$];
  mit_pkg::mit_out_t  expected_inverses[$];
  int                 errors;
  int                 push_idle_pct;
  int                 pop_idle_pct;

  matrix3_inverse_transpose u_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .mat   (mat),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Round C * 2^(IN_FRAC+OUT_FRAC) / det half away from zero, then saturate.
  // The shifted numerator reaches about 2^60, so 128-bit math keeps it exact.
  function automatic logic signed [mit_pkg::OUT_WIDTH-1:0] scaled_quotient(
      longint cof, longint det);
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] q;
    logic signed [127:0] maxpos;
    logic signed [127:0] maxneg;
    bit                  neg;
    neg = (cof < 0) != (det < 0);
    num = cof;
    den = det;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    num = num <<< (mit_pkg::IN_FRAC + mit_pkg::OUT_FRAC + 1);
    q = ((num / den) + 1) >>> 1;
    maxpos = (128'sd1 <<< (mit_pkg::OUT_WIDTH - 1)) - 1;
    maxneg = 128'sd1 <<< (mit_pkg::OUT_WIDTH - 1);
    if (neg) begin
      if (q > maxneg) q = maxneg;
      q = -q;
    end else if (q > maxpos) begin
      q = maxpos;
    end
    return q[mit_pkg::OUT_WIDTH-1:0];
  endfunction

  function automatic mit_pkg::mit_out_t inverse_transpose(mit_pkg::mit_in_t m);
    longint            a, b, c, d, e, f, g, h, k;
    longint            cof[9];
    longint            det;
    mit_pkg::mit_out_t r;
    a = m.m11; b = m.m12; c = m.m13;
    d = m.m21; e = m.m22; f = m.m23;
    g = m.m31; h = m.m32; k = m.m33;
    cof[0] = e * k - f * h;
    cof[1] = f * g - d * k;
    cof[2] = d * h - e * g;
    cof[3] = c * h - b * k;
    cof[4] = a * k - c * g;
    cof[5] = b * g - a * h;
    cof[6] = b * f - c * e;
    cof[7] = c * d - a * f;
    cof[8] = a * e - b * d;
    det = a * cof[0] + b * cof[1] + c * cof[2];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    r.r11 = scaled_quotient(cof[0], det);
    r.r12 = scaled_quotient(cof[1], det);
    r.r13 = scaled_quotient(cof[2], det);
    r.r21 = scaled_quotient(cof[3], det);
    r.r22 = scaled_quotient(cof[4], det);
    r.r23 = scaled_quotient(cof[5], det);
    r.r31 = scaled_quotient(cof[6], det);
    r.r32 = scaled_quotient(cof[7], det);
    r.r33 = scaled_quotient(cof[8], det);
    return r;
  endfunction

  function automatic mit_pkg::mit_in_t diag_mat(logic signed [15:0] x,
                                                logic signed [15:0] y,
                                                logic signed [15:0] z);
    mit_pkg::mit_in_t m;
    m = '0;
    m.m11 = x;
    m.m22 = y;
    m.m33 = z;
    return m;
  endfunction

  // Elements: mostly full-range random values, sometimes tiny, zero or extreme.
  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1:       return 16'($signed($urandom_range(0, 8)) - 4);
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mit_pkg::mit_in_t rand_mat();
    mit_pkg::mit_in_t m;
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // Make some rows dependent so that singular matrices show up.
    case ($urandom_range(0, 11))
      0: {m.m31, m.m32, m.m33} = {m.m11, m.m12, m.m13};
      1: {m.m21, m.m22, m.m23} = {m.m11 <<< 1, m.m12 <<< 1, m.m13 <<< 1};
      default: ;
    endcase
    return m;
  endfunction

  // Driver: advance to the next matrix once the current transaction is taken.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) expected_inverses.push_back(inverse_transpose(mat));
      if (pending_mats.size() > 0 && $urandom_range(0, 99) >= push_idle_pct) begin
        mat  <= pending_mats.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: check each popped result against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_inverses.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res);
          errors++;
        end else begin
          mit_pkg::mit_out_t want;
          want = expected_inverses.pop_front();
          if (res !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, res);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= pop_idle_pct);
    end
  end

  initial begin
    mit_pkg::mit_in_t m;
    errors        = 0;
    push_idle_pct = 11;
    pop_idle_pct  = 84;
    rst  = 1'b1;
    push = 1'b0;
    pop  = 1'b0;
    mat  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: identity, scaled diagonals, extremes, singular cases.
    pending_mats.push_back(diag_mat(16'sh1000, 16'sh1000, 16'sh1000));
    pending_mats.push_back(diag_mat(16'sh2000, -16'sh1000, 16'sh0800));
    pending_mats.push_back(diag_mat(16'sh7fff, 16'sh7fff, 16'sh7fff));
    pending_mats.push_back(diag_mat(-16'sh8000, -16'sh8000, -16'sh8000));
    pending_mats.push_back(diag_mat(16'sh0001, 16'sh0001, 16'sh0001));
    pending_mats.push_back(diag_mat(-16'sh0001, 16'sh0001, 16'sh7fff));
    pending_mats.push_back(diag_mat(16'sh0003, 16'sh1000, 16'sh1000));
    pending_mats.push_back(diag_mat(-16'sh8000, 16'sh0001, 16'sh0001));
    pending_mats.push_back('0);
    pending_mats.push_back(diag_mat(16'sh1000, 16'sh1000, 16'sh0000));
    m = {9{16'h7fff}};
    pending_mats.push_back(m);
    m = {9{16'h8000}};
    pending_mats.push_back(m);
    m = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
         16'h7fff, 16'h7fff, 16'h8000};
    pending_mats.push_back(m);
    m = {16'hffff, 16'h5555, 16'haaaa, 16'h0001, 16'hffff, 16'h1234,
         16'hedcb, 16'h8001, 16'h7ffe};
    pending_mats.push_back(m);
    // permutation matrix gives exact unit entries
    m = '0;
    m.m12 = 16'sh1000;
    m.m23 = 16'sh1000;
    m.m31 = -16'sh1000;
    pending_mats.push_back(m);
    // rounding of an inexact quotient: det = 3, one cofactor is 1
    m = diag_mat(16'sh0001, 16'sh0001, 16'sh0003);
    m.m12 = 16'sh0001;
    pending_mats.push_back(m);

    // Random, in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < NUM_RANDOM / 3; i++) pending_mats.push_back(rand_mat());
      while (pending_mats.size() > 0) @(posedge clk);
      if (phase == 0) begin
        push_idle_pct = 84;
        pop_idle_pct  = 11;
      end else begin
        push_idle_pct = 0;
        pop_idle_pct  = 0;
      end
    end
    push_idle_pct = 0;
    pop_idle_pct  = 0;

    // Drain: let the last push settle, wait for all results, then idle a while.
    @(posedge clk);
    while (push || expected_inverses.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hang; far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/mit_pkg.sv
rtl/mit_front.sv
rtl/mit_queue.sv
rtl/mit_back.sv
rtl/matrix3_inverse_transpose.sv
bench/matrix3_inverse_transpose_test.sv
